// ===== src/bte_pkg.sv =====
`timescale 1ns / 1ps

package bte_pkg;

  localparam int MAX_SIDE_DEF = 16;

  localparam int SIDE_W   = 5;
  localparam int MODE_W   = 3;
  localparam int OP_W     = 2;
  localparam int COORD_W  = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_SYM   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_COPY   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT_CW = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MIR_LR = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MIR_TB = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SCALE2 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SCALE4 = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd1;

endpackage

// ===== src/bte_ram.sv =====
`timescale 1ns / 1ps

module bte_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

// ===== src/bitmap_transform_engine.sv =====
`timescale 1ns / 1ps
// Write transaction: stored at the accepting edge, no result.
// Read transaction: RAM data is registered in ST_RD, then loaded into the result;
// input stalls until idle. Symmetry query: one pair per cycle from a dual-read
// pixel RAM; input stalls until the query result is loaded.
// Reset (async, active low) sets side to 16 and mode to copy; pixel RAM is not cleared.

module bitmap_transform_engine import bte_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       operation_i,
  input  logic [COORD_W-1:0]    row_i,
  input  logic [COORD_W-1:0]    col_i,
  input  logic                  pixel_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  pixel_out_o,
  output logic                  in_range_o,
  output logic                  symmetric_o
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int CW    = $clog2(MAX_SIDE + 2);
  localparam int TW    = SIDE_W + 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_SYM  = 2'd2;

  function automatic logic [AW-1:0] pix_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
    return AW'(r) * AW'(MAX_SIDE) + AW'(c);
  endfunction

  logic [SIDE_W-1:0] side_q;
  logic [MODE_W-1:0] mode_q;
  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d;
  logic              cmp_q, cmp_d;
  logic              acc_q, acc_d;
  logic              rd_ok_q, rd_ok_d;
  logic              out_valid_q, out_valid_d;
  logic              pix_q, pix_d, rng_q, rng_d, sym_q, sym_d;

  logic [SIDE_W-1:0]  s_eff;
  logic [CW-1:0]      s_cw;
  logic [TW-1:0]      t_size;
  logic [COORD_W-1:0] s_m1, rd_r, rd_c;
  logic               rd_ok, wr_ok;
  logic               out_free, in_acc;
  logic               we;
  logic [AW-1:0]      waddr, raddr_a, raddr_b;
  logic               rdata_a, rdata_b;
  logic               pair_eq;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SIDE_RESET;
      mode_q <= MODE_COPY;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SIDE: side_q <= cfg_data_i;
        REG_MODE: mode_q <= cfg_data_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (side_q == '0) begin
      s_eff = SIDE_W'(1);
    end else if (32'(side_q) > MAX_SIDE) begin
      s_eff = SIDE_W'(MAX_SIDE);
    end else begin
      s_eff = side_q;
    end
  end

  assign s_cw  = CW'(s_eff);
  assign s_m1  = COORD_W'(s_eff) - COORD_W'(1);
  assign wr_ok = (row_i < COORD_W'(s_eff)) && (col_i < COORD_W'(s_eff));

  // transformed coordinate decode
  always_comb begin
    t_size = TW'(s_eff);
    rd_r   = row_i;
    rd_c   = col_i;
    unique case (mode_q)
      MODE_ROT_CW: begin
        rd_r = s_m1 - col_i;
        rd_c = row_i;
      end
      MODE_MIR_LR: rd_c = s_m1 - col_i;
      MODE_MIR_TB: rd_r = s_m1 - row_i;
      MODE_SCALE2: begin
        t_size = TW'(s_eff) << 1;
        rd_r   = row_i >> 1;
        rd_c   = col_i >> 1;
      end
      MODE_SCALE4: begin
        t_size = TW'(s_eff) << 2;
        rd_r   = row_i >> 2;
        rd_c   = col_i >> 2;
      end
      default: ;
    endcase
  end

  assign rd_ok = (TW'(row_i) < t_size) && (TW'(col_i) < t_size);

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_IDLE) && out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign we    = in_acc && (operation_i == OP_WRITE) && wr_ok;
  assign waddr = pix_addr(row_i[IW-1:0], col_i[IW-1:0]);

  always_comb begin
    if (state_q == ST_SYM) begin
      raddr_a = pix_addr(i_q[IW-1:0], j_q[IW-1:0]);
      raddr_b = pix_addr(j_q[IW-1:0], i_q[IW-1:0]);
    end else begin
      raddr_a = rd_ok ? pix_addr(rd_r[IW-1:0], rd_c[IW-1:0]) : '0;
      raddr_b = '0;
    end
  end

  bte_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (pixel_i),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  assign pair_eq = !cmp_q || (rdata_a == rdata_b);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    cmp_d       = 1'b0;
    acc_d       = acc_q;
    rd_ok_d     = rd_ok_q;
    out_valid_d = out_valid_q && out_stall_i;
    pix_d       = pix_q;
    rng_d       = rng_q;
    sym_d       = sym_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (operation_i == OP_READ) begin
            rd_ok_d = rd_ok;
            state_d = ST_RD;
          end else if (operation_i == OP_SYM) begin
            i_d     = '0;
            j_d     = CW'(1);
            acc_d   = 1'b1;
            state_d = ST_SYM;
          end
        end
      end
      ST_RD: begin
        out_valid_d = 1'b1;
        pix_d       = rd_ok_q & rdata_a;
        rng_d       = rd_ok_q;
        sym_d       = 1'b0;
        state_d     = ST_IDLE;
      end
      ST_SYM: begin
        acc_d = acc_q & pair_eq;
        if (j_q < s_cw) begin
          cmp_d = 1'b1;
          if (j_q + CW'(1) < s_cw) begin
            j_d = j_q + CW'(1);
          end else begin
            i_d = i_q + CW'(1);
            j_d = i_q + CW'(2);
          end
        end else begin
          out_valid_d = 1'b1;
          pix_d       = 1'b0;
          rng_d       = 1'b0;
          sym_d       = acc_q & pair_eq;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cmp_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cmp_q       <= cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    j_q     <= j_d;
    acc_q   <= acc_d;
    rd_ok_q <= rd_ok_d;
    pix_q   <= pix_d;
    rng_q   <= rng_d;
    sym_q   <= sym_d;
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_q;
  assign in_range_o  = rng_q;
  assign symmetric_o = sym_q;

`ifndef ASSERT_OFF
  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

  a_rd_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |-> !out_valid_q)
    else $error("read result would overwrite pending result");

  a_rd_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("read result not loaded");

  a_sym_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SYM) && (j_q < s_cw)) |=> cmp_q)
    else $error("symmetry pair issued without compare");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(rng_q && sym_q))
    else $error("read and query flags both set");
`endif

endmodule
